// ----- rtl/tkss_pkg.sv -----
`timescale 1ns / 1ps

package tkss_pkg;

   localparam int MAX_KEEP_DEFAULT = 64;
   localparam int KEEP_W = 7;
   localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd10;
   localparam int ID_W = 32;
   localparam int DIST_W = 32;

   localparam logic [1:0] OP_OFFER = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]               operation;
      logic [ID_W-1:0]          doc_id;
      logic signed [DIST_W-1:0] distance;
      logic                     distance_valid;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]          out_doc_id;
      logic signed [DIST_W-1:0] out_distance;
      logic                     store_empty;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]          id;
      logic signed [DIST_W-1:0] distance;
   } entry_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } cell_ctl_type;

   // a ranks strictly better than b: smaller distance, then larger id
   function automatic logic ranks_better(input entry_type a, input entry_type b);
      logic result;
      if (a.distance != b.distance) begin
         result = a.distance < b.distance;
      end else begin
         result = a.id > b.id;
      end
      return result;
   endfunction

endpackage

// ----- rtl/tkss_cell.sv -----
`timescale 1ns / 1ps

module tkss_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  logic                    clock,
   input  tkss_pkg::cell_ctl_type  ctl,
   input  logic [CNT_W-1:0]        held,
   input  tkss_pkg::entry_type     new_entry,
   input  tkss_pkg::entry_type     left_entry,
   input  tkss_pkg::entry_type     right_entry,
   input  logic                    left_better,
   output tkss_pkg::entry_type     entry,
   output logic                    better,
   output logic                    worst_lt
);

   tkss_pkg::entry_type entry_ff, entry_in;
   logic occupied;
   logic is_last;

   assign occupied = held > CNT_W'(INDEX);
   assign is_last  = held == CNT_W'(INDEX + 1);
   assign better   = !occupied || tkss_pkg::ranks_better(new_entry, entry_ff);
   assign worst_lt = is_last && (new_entry.distance < entry_ff.distance);
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert) begin
         if (better && left_better) begin
            entry_in = left_entry;
         end else if (better) begin
            entry_in = new_entry;
         end
      end else if (ctl.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ----- rtl/top_k_smallest_score_selector.sv -----
`timescale 1ns / 1ps

// Keeps the k best (smallest distance) candidates offered on the request
// channel, sorted best first in a chain of cells.
// Request channel (req_valid, req_stall, req_data): operation offer, read or
// clear. One request is taken per cycle; an offer or clear finishes in the
// cycle it is taken, the whole chain shifting or inserting in one step.
// A read returns the best entry on the response channel (rsp_valid,
// rsp_stall, rsp_data) in the cycle after it is taken, from an output register;
// an empty store answers with store_empty set and zero id and distance.
// One request per cycle outside read stalls, set by single-step insert or pop
// across all cells. While a response waits under rsp_stall, offers and clears
// are still taken; a further read is stalled until the response leaves.
// csr_write_enable/csr_write_data set keep_count (k); the k used saturates at MAX_KEEP.
// Reset (synchronous) empties the store, drops any pending response and sets
// keep_count to 10.

module top_k_smallest_score_selector #(
   parameter int MAX_KEEP = tkss_pkg::MAX_KEEP_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  tkss_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output tkss_pkg::rsp_type             rsp_data,
   input  logic                          csr_write_enable,
   input  logic [tkss_pkg::KEEP_W-1:0]   csr_write_data
);

   localparam int CNT_W = $clog2(MAX_KEEP + 1);
   localparam int CMP_W = (CNT_W > tkss_pkg::KEEP_W) ? CNT_W : tkss_pkg::KEEP_W;

   logic [tkss_pkg::KEEP_W-1:0] keep_count_ff, keep_count_in;
   logic [CNT_W-1:0]            held_ff, held_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   tkss_pkg::rsp_type           rsp_data_ff, rsp_data_in;

   tkss_pkg::entry_type         entry_w [MAX_KEEP];
   logic [MAX_KEEP-1:0]         better_w;
   logic [MAX_KEEP-1:0]         worst_lt_w;
   tkss_pkg::entry_type         new_entry;
   tkss_pkg::cell_ctl_type      ctl;

   logic        accept;
   logic        is_offer, is_read, is_clear;
   logic [CMP_W-1:0] k_eff, held_ext;
   logic        room, replace;

   assign req_stall = rsp_valid_ff && rsp_stall && (req_data.operation == tkss_pkg::OP_READ);
   assign accept    = req_valid && !req_stall;
   assign is_offer  = accept && (req_data.operation == tkss_pkg::OP_OFFER)
                      && req_data.distance_valid;
   assign is_read   = accept && (req_data.operation == tkss_pkg::OP_READ);
   assign is_clear  = accept && (req_data.operation == tkss_pkg::OP_CLEAR);

   assign new_entry.id       = req_data.doc_id;
   assign new_entry.distance = req_data.distance;

   assign k_eff    = (CMP_W'(keep_count_ff) > CMP_W'(MAX_KEEP)) ? CMP_W'(MAX_KEEP)
                                                               : CMP_W'(keep_count_ff);
   assign held_ext = CMP_W'(held_ff);
   assign room     = held_ext < k_eff;
   assign replace  = (k_eff != '0) && !room && (held_ff != '0) && (|worst_lt_w);

   assign ctl.insert = is_offer && (k_eff != '0) && (room || replace);
   assign ctl.pop    = is_read && (held_ff != '0);

   always_comb begin
      held_in = held_ff;
      if (is_clear) begin
         held_in = '0;
      end else if (ctl.insert && room) begin
         held_in = held_ff + CNT_W'(1);
      end else if (ctl.pop) begin
         held_in = held_ff - CNT_W'(1);
      end
   end

   always_comb begin
      keep_count_in = keep_count_ff;
      if (csr_write_enable) begin
         keep_count_in = csr_write_data;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (is_read) begin
         rsp_valid_in = 1'b1;
         if (held_ff == '0) begin
            rsp_data_in = '{out_doc_id: '0, out_distance: '0, store_empty: 1'b1};
         end else begin
            rsp_data_in = '{out_doc_id: entry_w[0].id, out_distance: entry_w[0].distance,
                            store_empty: 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_count_ff <= tkss_pkg::KEEP_RESET;
         held_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         keep_count_ff <= keep_count_in;
         held_ff       <= held_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
      tkss_pkg::entry_type left_e, right_e;
      logic left_b;
      if (i == 0) begin : g_first
         assign left_e = new_entry;
         assign left_b = 1'b0;
      end else begin : g_mid
         assign left_e = entry_w[i-1];
         assign left_b = better_w[i-1];
      end
      if (i == MAX_KEEP - 1) begin : g_last
         assign right_e = entry_w[i];
      end else begin : g_inner
         assign right_e = entry_w[i+1];
      end
      tkss_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .held        (held_ff),
         .new_entry   (new_entry),
         .left_entry  (left_e),
         .right_entry (right_e),
         .left_better (left_b),
         .entry       (entry_w[i]),
         .better      (better_w[i]),
         .worst_lt    (worst_lt_w[i])
      );
   end

endmodule

// ----- test/top_k_smallest_score_selector_checker.sv -----
`timescale 1ns / 1ps

module top_k_smallest_score_selector_checker
   import tkss_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  req_type           req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rsp_type           rsp_data,
   input  logic              csr_write_enable,
   input  logic [KEEP_W-1:0] csr_write_data,
   output int                fail_count,
   output int                pending_reads
);

   localparam int ENTRY_CAP = MAX_KEEP_DEFAULT;

   logic [KEEP_W-1:0] keep_count;
   entry_type         kept_entries[$];   // best first
   rsp_type           pops_due[$];

   function automatic logic outranks(input entry_type a, input entry_type b);
      if ($signed(a.distance) != $signed(b.distance)) begin
         return $signed(a.distance) < $signed(b.distance);
      end
      return a.id > b.id;
   endfunction

   task automatic place_entry(input entry_type e);
      int pos;
      pos = 0;
      while (pos < kept_entries.size() && !outranks(e, kept_entries[pos])) begin
         pos++;
      end
      kept_entries.insert(pos, e);
   endtask

   task automatic take_offer(input entry_type e);
      int k_eff;
      k_eff = (keep_count > ENTRY_CAP) ? ENTRY_CAP : int'(keep_count);
      if (k_eff == 0) begin
         return;
      end
      if (kept_entries.size() < k_eff) begin
         place_entry(e);
      end else if (kept_entries.size() != 0 &&
                   $signed(e.distance) < $signed(kept_entries[$].distance)) begin
         void'(kept_entries.pop_back());
         place_entry(e);
      end
   endtask

   task automatic apply_request(input req_type r);
      entry_type e;
      rsp_type   pop;
      case (r.operation)
         OP_OFFER: begin
            if (r.distance_valid) begin
               e.id       = r.doc_id;
               e.distance = r.distance;
               take_offer(e);
            end
         end
         OP_READ: begin
            pop = '0;
            if (kept_entries.size() == 0) begin
               pop.store_empty = 1'b1;
            end else begin
               e = kept_entries.pop_front();
               pop.out_doc_id   = e.id;
               pop.out_distance = e.distance;
            end
            pops_due.push_back(pop);
         end
         OP_CLEAR: begin
            kept_entries.delete();
         end
         default: begin
         end
      endcase
   endtask

   // sampled at the falling edge: everything here is stable until the next rising edge
   always @(negedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         keep_count = KEEP_RESET;
         kept_entries.delete();
         pops_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pops_due.size() == 0) begin
               fail_count++;
               $error("response with no read outstanding");
            end else begin
               want = pops_due.pop_front();
               if (rsp_data.out_doc_id !== want.out_doc_id) begin
                  fail_count++;
                  $error("out_doc_id: expected %0h, got %0h",
                         want.out_doc_id, rsp_data.out_doc_id);
               end
               if (rsp_data.out_distance !== want.out_distance) begin
                  fail_count++;
                  $error("out_distance: expected %0d, got %0d",
                         $signed(want.out_distance), $signed(rsp_data.out_distance));
               end
               if (rsp_data.store_empty !== want.store_empty) begin
                  fail_count++;
                  $error("store_empty: expected %0b, got %0b",
                         want.store_empty, rsp_data.store_empty);
               end
            end
         end
         if (req_valid && !req_stall) begin
            apply_request(req_data);
         end
         if (csr_write_enable) begin
            keep_count = csr_write_data;
         end
      end
      pending_reads = pops_due.size();
   end

endmodule

// ----- test/tb_top_k_smallest_score_selector.sv -----
`timescale 1ns / 1ps

module tb_top_k_smallest_score_selector;
   import tkss_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   rsp_type           rsp_data;
   logic              csr_write_enable = 1'b0;
   logic [KEEP_W-1:0] csr_write_data = '0;

   int   fail_count;
   int   pending_reads;
   bit   calm = 1'b0;
   logic hold_request = 1'b0;

   always #1 clock = ~clock;

   top_k_smallest_score_selector dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   top_k_smallest_score_selector_checker selector_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_reads    (pending_reads)
   );

   // response side: random stalls, plus one long hold-off
   always @(posedge clock) begin : receiver
      int hold_left;
      bit hold_used;
      if (hold_request && !hold_used) begin
         hold_used = 1'b1;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 18);
      end
   end

   function automatic req_type request_of(input logic [1:0] op, input logic [31:0] id,
                                          input logic [31:0] score, input logic ok);
      req_type r;
      r.operation      = op;
      r.doc_id         = id;
      r.distance       = score;
      r.distance_valid = ok;
      return r;
   endfunction

   function automatic req_type random_request(input int read_pct);
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      r.doc_id = $urandom_range(1) ? $urandom : $urandom_range(7);
      r.distance = $urandom_range(1) ? $urandom : ($urandom_range(40) - 20);
      r.distance_valid = $urandom_range(99) >= 8;
      if (pick < read_pct) begin
         r.operation = OP_READ;
      end else if (pick < read_pct + 3) begin
         r.operation = OP_CLEAR;
      end else if (pick < read_pct + 5) begin
         r.operation = OP_UNUSED;
      end else begin
         r.operation = OP_OFFER;
      end
      return r;
   endfunction

   task automatic send(input req_type r);
      logic taken;
      if (!calm && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_reads != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_keep(input int k);
      csr_write_data   <= k[KEEP_W-1:0];
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      #2_000_000;
      $display("top_k_smallest_score_selector test failed");
      $finish;
   end

   initial begin
      int keep_plan[10];
      int read_plan[10];
      keep_plan = '{64, 1, 127, 3, 32, 65, 2, 16, 8, 10};
      read_plan = '{10, 30, 10, 25, 15, 12, 30, 20, 25, 20};
      keep_plan[9] = $urandom_range(1, 64);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default k, extremes, deleted doc, tie on distance, unused op, clear
      send(request_of(OP_READ, '0, '0, 1'b0));
      send(request_of(OP_OFFER, 32'h0, 32'h7FFF_FFFF, 1'b1));
      send(request_of(OP_OFFER, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1));
      send(request_of(OP_OFFER, 32'h1234, 32'h0, 1'b0));
      send(request_of(OP_OFFER, 32'd5, 32'h0, 1'b1));
      send(request_of(OP_OFFER, 32'd6, 32'h0, 1'b1));
      send(request_of(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
      repeat (5) send(request_of(OP_READ, '0, '0, 1'b0));
      send(request_of(OP_OFFER, 32'd7, 32'h3, 1'b1));
      send(request_of(OP_CLEAR, '0, '0, 1'b0));
      send(request_of(OP_READ, '0, '0, 1'b0));

      // k of one: equal to worst is rejected, better replaces
      wait_idle();
      set_keep(1);
      send(request_of(OP_OFFER, 32'd1, 32'd5, 1'b1));
      send(request_of(OP_OFFER, 32'd2, 32'd5, 1'b1));
      send(request_of(OP_OFFER, 32'd3, 32'd4, 1'b1));
      repeat (2) send(request_of(OP_READ, '0, '0, 1'b0));

      // k of zero ignores offers but reads still drain
      wait_idle();
      set_keep(3);
      for (int i = 0; i < 3; i++) begin
         send(request_of(OP_OFFER, i, i, 1'b1));
      end
      wait_idle();
      set_keep(0);
      send(request_of(OP_OFFER, 32'd9, 32'h8000_0000, 1'b1));
      repeat (4) send(request_of(OP_READ, '0, '0, 1'b0));

      // k lowered below the held count
      wait_idle();
      set_keep(8);
      for (int i = 1; i <= 8; i++) begin
         send(request_of(OP_OFFER, i, i, 1'b1));
      end
      wait_idle();
      set_keep(2);
      send(request_of(OP_OFFER, 32'd20, 32'd0, 1'b1));
      send(request_of(OP_OFFER, 32'd21, 32'd100, 1'b1));
      repeat (9) send(request_of(OP_READ, '0, '0, 1'b0));

      // k above the capacity saturates
      wait_idle();
      set_keep(127);
      repeat (70) send(random_request(0));
      repeat (66) send(request_of(OP_READ, '0, '0, 1'b0));

      for (int p = 0; p < 10; p++) begin
         wait_idle();
         set_keep(keep_plan[p]);
         calm <= (p == 4);
         if (p == 6) begin
            hold_request <= 1'b1;
         end
         repeat (52) send(random_request(p == 6 ? 40 : read_plan[p]));
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_reads == 0) begin
         $display("top_k_smallest_score_selector test passed");
      end else begin
         $display("top_k_smallest_score_selector test failed");
      end
      $finish;
   end

endmodule
